/* rtl/core/bmr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the BLE MIDI reassembler.
// Used by the controller, the datapath and the top level; depends on nothing.
package bmr_pkg;

  // Ring store geometry.
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 10;
  localparam int MLEN_W = 9;

  // MIDI byte codes.
  localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
  localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
  localparam int                HIGH_BIT    = 7;

  // Fixed message lengths.
  localparam logic [MLEN_W-1:0] LEN_SHORT  = MLEN_W'(1);
  localparam logic [MLEN_W-1:0] LEN_NORMAL = MLEN_W'(3);

  // Operation codes.
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_MSG  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRST,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RD_WAIT
  } state_e;

  // Source of the store read address.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_IDX,
    RD_POS
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    do_byte;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    eval_first;
    logic    scan_chk;
    logic    load_read;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic empty;
    logic sysex_head;
    logic scan_end;
    logic scan_hit;
  } sts_t;

endpackage

/* rtl/core/ble_midi_reassembler_unit.sv */
`timescale 1ns / 1ps
// BLE MIDI reassembler top level. A packet byte, an unknown op or an empty-store take
// finish in the execute state; a store read adds the read-wait state, a fixed-length
// take the first-byte state, and a sysex take a scan read and check per byte scanned.
// One beat at a time: busy is high until the result strobe cycle, so a new beat can
// be taken at the edge that takes the result. Reset is asynchronous, active low, clears
// pointers and flags; the store is not cleared. The receiver cannot stall.
module ble_midi_reassembler_unit import bmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_of_packet_i,
  input  logic [PLEN_W-1:0] packet_len_i,
  input  logic [7:0]        read_index_i,
  output logic              done_o,
  output logic              accepted_o,
  output logic              found_o,
  output logic [7:0]        msg_offset_o,
  output logic [MLEN_W-1:0] msg_length_o,
  output logic [BYTE_W-1:0] read_data_o
);

  cmd_t cmd;
  sts_t sts;

  bmr_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy),
    .done_o(done_o)
  );

  bmr_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .first_of_packet_i(first_of_packet_i),
    .packet_len_i     (packet_len_i),
    .read_index_i     (read_index_i),
    .accepted_o       (accepted_o),
    .found_o          (found_o),
    .msg_offset_o     (msg_offset_o),
    .msg_length_o     (msg_length_o),
    .read_data_o      (read_data_o)
  );

endmodule

/* rtl/core/bmr_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Stand-alone; no package dependency.
module bmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: write, or read with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bmr_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the BLE MIDI reassembler.
// Depends on bmr_pkg; drives the datapath through cmd_t and reads sts_t.
module bmr_ctrl import bmr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic done_o
);

  state_e state_q, state_d;
  logic   finish;
  logic   done_q;

  // State register and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (sts_i.op)
          OP_MSG:  state_d = sts_i.empty ? ST_IDLE : ST_FIRST;
          OP_READ: state_d = ST_RD_WAIT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FIRST: begin
        state_d = sts_i.sysex_head ? ST_SCAN_RD : ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_d = sts_i.scan_end ? ST_IDLE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_d = sts_i.scan_hit ? ST_IDLE : ST_SCAN_RD;
      end
      ST_RD_WAIT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and completion.
  always_comb begin
    cmd_o  = '0;
    cmd_o.rd_sel = RD_PTR;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start;
      end
      ST_EXEC: begin
        unique case (sts_i.op)
          OP_BYTE: begin
            cmd_o.do_byte = 1'b1;
            finish        = 1'b1;
          end
          OP_MSG: begin
            cmd_o.rd_en  = !sts_i.empty;
            cmd_o.rd_sel = RD_PTR;
            finish       = sts_i.empty;
          end
          OP_READ: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_IDX;
          end
          default: finish = 1'b1;
        endcase
      end
      ST_FIRST: begin
        cmd_o.eval_first = 1'b1;
        finish           = !sts_i.sysex_head;
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en  = !sts_i.scan_end;
        cmd_o.rd_sel = RD_POS;
        finish       = sts_i.scan_end;
      end
      ST_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        finish         = sts_i.scan_hit;
      end
      ST_RD_WAIT: begin
        cmd_o.load_read = 1'b1;
        finish          = 1'b1;
      end
      default: finish = 1'b0;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* rtl/core/bmr_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the BLE MIDI reassembler: pointers, packet flags, scan
// registers, result registers and the ring store. Depends on bmr_pkg, bmr_ram.
module bmr_datapath import bmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_of_packet_i,
  input  logic [PLEN_W-1:0] packet_len_i,
  input  logic [7:0]        read_index_i,
  output logic              accepted_o,
  output logic              found_o,
  output logic [7:0]        msg_offset_o,
  output logic [MLEN_W-1:0] msg_length_o,
  output logic [BYTE_W-1:0] read_data_o
);

  // Captured beat.
  op_e               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic              first_q;
  logic [PLEN_W-1:0] len_q;
  logic [7:0]        idx_q;

  // Persistent state.
  logic [ADDR_W-1:0] wi_q, wi_d;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic              ts_q, ts_d;
  logic              drop_q, drop_d;

  // Sysex scan.
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [MLEN_W-1:0] cnt_q, cnt_d;

  // Results.
  logic              acc_q, acc_d;
  logic              found_q, found_d;
  logic [7:0]        off_q, off_d;
  logic [MLEN_W-1:0] mlen_q, mlen_d;
  logic [BYTE_W-1:0] rd_q, rd_d;

  // Store port.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] space;
  logic [ADDR_W-1:0] fill;
  logic [MLEN_W-1:0] need;

  assign space = rp_q - wi_q - ADDR_W'(1);
  assign fill  = wi_q - rp_q;
  assign need  = (ram_rdata == SYSEX_END) ? LEN_SHORT : LEN_NORMAL;

  // Capture the input beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      byte_q  <= data_byte_i;
      first_q <= first_of_packet_i;
      len_q   <= packet_len_i;
      idx_q   <= read_index_i;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      rp_q   <= '0;
      ts_q   <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      wi_q   <= wi_d;
      rp_q   <= rp_d;
      ts_q   <= ts_d;
      drop_q <= drop_d;
    end
  end

  // Scan and result registers.
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    found_q <= found_d;
    off_q   <= off_d;
    mlen_q  <= mlen_d;
    rd_q    <= rd_d;
  end

  // Next-state logic for all operations.
  always_comb begin
    wi_d    = wi_q;
    rp_d    = rp_q;
    ts_d    = ts_q;
    drop_d  = drop_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    found_d = found_q;
    off_d   = off_q;
    mlen_d  = mlen_q;
    rd_d    = rd_q;
    ram_we  = 1'b0;

    if (cmd_i.capture) begin
      acc_d   = 1'b0;
      found_d = 1'b0;
      off_d   = '0;
      mlen_d  = '0;
      rd_d    = '0;
    end

    // Packet byte: header decision, timestamp skipping, store write.
    if (cmd_i.do_byte) begin
      if (first_q) begin
        ts_d   = 1'b0;
        drop_d = (32'(space) < 32'(len_q));
        acc_d  = !(32'(space) < 32'(len_q));
      end else if (drop_q) begin
        acc_d = 1'b0;
      end else begin
        acc_d = 1'b1;
        if (byte_q[HIGH_BIT] && !ts_q) begin
          ts_d = 1'b1;
        end else begin
          if (byte_q[HIGH_BIT]) ts_d = 1'b0;
          ram_we = 1'b1;
          wi_d   = wi_q + ADDR_W'(1);
        end
      end
    end

    // First byte of a message: fixed-length framing or sysex scan setup.
    if (cmd_i.eval_first) begin
      if (ram_rdata == SYSEX_START) begin
        pos_d = rp_q + ADDR_W'(1);
        cnt_d = MLEN_W'(1);
      end else if (MLEN_W'(fill) >= need) begin
        found_d = 1'b1;
        off_d   = 8'(rp_q);
        mlen_d  = need;
        rp_d    = rp_q + ADDR_W'(need);
      end
    end

    // Sysex scan step: stop at the next high-bit byte.
    if (cmd_i.scan_chk) begin
      cnt_d = cnt_q + MLEN_W'(1);
      if (ram_rdata[HIGH_BIT]) begin
        found_d = 1'b1;
        off_d   = 8'(rp_q);
        mlen_d  = cnt_q + MLEN_W'(1);
        rp_d    = pos_q;
      end else begin
        pos_d = pos_q + ADDR_W'(1);
      end
    end

    if (cmd_i.load_read) begin
      rd_d = ram_rdata;
    end
  end

  // Store address selection.
  always_comb begin
    ram_re = cmd_i.rd_en;
    if (cmd_i.do_byte) begin
      ram_addr = wi_q;
    end else begin
      unique case (cmd_i.rd_sel)
        RD_PTR:  ram_addr = rp_q;
        RD_IDX:  ram_addr = ADDR_W'(idx_q);
        RD_POS:  ram_addr = pos_q;
        default: ram_addr = rp_q;
      endcase
    end
  end

  bmr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(byte_q),
    .rdata_o(ram_rdata)
  );

  // Status toward the controller.
  assign sts_o.op         = op_q;
  assign sts_o.empty      = (rp_q == wi_q);
  assign sts_o.sysex_head = (ram_rdata == SYSEX_START);
  assign sts_o.scan_end   = (pos_q == wi_q);
  assign sts_o.scan_hit   = ram_rdata[HIGH_BIT];

  assign accepted_o   = acc_q;
  assign found_o      = found_q;
  assign msg_offset_o = off_q;
  assign msg_length_o = mlen_q;
  assign read_data_o  = rd_q;

endmodule

/* sim/ble_midi_reassembler_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the BLE MIDI reassembler top level.
// Depends on bmr_pkg and ble_midi_reassembler_unit; predicts every result beat in step.
module ble_midi_reassembler_unit_tb;
  import bmr_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 12;
  localparam int ITEMS_TARGET = 1650;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int TAIL_CYCLES  = 32;
  localparam int MAX_PRINTED  = 40;

  // One expected result beat, one field per output port.
  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [7:0]        offset;
    logic [MLEN_W-1:0] length;
    logic [BYTE_W-1:0] rdata;
  } midi_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        op_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              first_of_packet_i;
  logic [PLEN_W-1:0] packet_len_i;
  logic [7:0]        read_index_i;
  logic              done_o;
  logic              accepted_o;
  logic              found_o;
  logic [7:0]        msg_offset_o;
  logic [MLEN_W-1:0] msg_length_o;
  logic [BYTE_W-1:0] read_data_o;

  // Predicted ring store and framing state.
  logic [BYTE_W-1:0] ring_mem [STORE_DEPTH];
  bit                ring_written [STORE_DEPTH];
  logic [ADDR_W-1:0] wr_pos;
  logic [ADDR_W-1:0] rd_pos;
  logic              ts_pending;
  logic              pkt_rejected;

  midi_result_t expected_results[$];
  int           n_errors = 0;
  int           n_items = 0;
  int           cycle_count = 0;
  bit           gaps_enabled = 1'b1;

  ble_midi_reassembler_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .op_i              (op_i),
    .data_byte_i       (data_byte_i),
    .first_of_packet_i (first_of_packet_i),
    .packet_len_i      (packet_len_i),
    .read_index_i      (read_index_i),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .found_o           (found_o),
    .msg_offset_o      (msg_offset_o),
    .msg_length_o      (msg_length_o),
    .read_data_o       (read_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("[%0t] %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Works out the result of one accepted beat and advances the predicted state.
  function automatic midi_result_t predict_beat(op_e op, logic [7:0] data, logic hdr,
                                                logic [PLEN_W-1:0] plen, logic [7:0] ridx);
    midi_result_t      r;
    logic [ADDR_W-1:0] space;
    logic [ADDR_W-1:0] avail;
    logic [ADDR_W-1:0] pos;
    int                count;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (hdr) begin
          // The header decides the whole packet against the free space.
          ts_pending   = 1'b0;
          space        = rd_pos - wr_pos - ADDR_W'(1);
          pkt_rejected = (space < plen);
          r.accepted   = !pkt_rejected;
        end else if (!pkt_rejected) begin
          r.accepted = 1'b1;
          // High-bit bytes alternate between timestamp (dropped) and status (kept).
          if (data[HIGH_BIT] && !ts_pending) begin
            ts_pending = 1'b1;
          end else begin
            if (data[HIGH_BIT]) ts_pending = 1'b0;
            ring_mem[wr_pos]     = data;
            ring_written[wr_pos] = 1'b1;
            wr_pos               = wr_pos + ADDR_W'(1);
          end
        end
      end
      OP_MSG: begin
        if (rd_pos != wr_pos) begin
          if (ring_mem[rd_pos] == SYSEX_START) begin
            // Sysex ends on the next high-bit byte, which stays for the next message.
            pos   = rd_pos;
            count = 0;
            while (pos != wr_pos) begin
              count++;
              if (count > 1 && ring_mem[pos][HIGH_BIT]) begin
                r.found  = 1'b1;
                r.offset = rd_pos;
                r.length = MLEN_W'(count);
                rd_pos   = pos;
                return r;
              end
              pos = pos + ADDR_W'(1);
            end
          end else begin
            avail    = wr_pos - rd_pos;
            r.length = (ring_mem[rd_pos] == SYSEX_END) ? LEN_SHORT : LEN_NORMAL;
            if (avail >= r.length) begin
              r.found  = 1'b1;
              r.offset = rd_pos;
              rd_pos   = rd_pos + ADDR_W'(r.length);
            end else begin
              r.length = '0;
            end
          end
        end
      end
      OP_READ: r.rdata = ring_mem[ridx];
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offers one beat, waits for it to be taken, and records its expected result.
  task automatic send_beat(op_e op, logic [7:0] data, logic hdr,
                           logic [PLEN_W-1:0] plen, logic [7:0] ridx);
    midi_result_t r;
    int           gap;
    start             <= 1'b1;
    op_i              <= op;
    data_byte_i       <= data;
    first_of_packet_i <= hdr;
    packet_len_i      <= plen;
    read_index_i      <= ridx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = predict_beat(op, data, hdr, plen, ridx);
    expected_results.push_back(r);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put_byte(logic [7:0] data);
    send_beat(OP_BYTE, data, 1'b0, PLEN_W'($urandom_range(0, 512)), 8'($urandom));
  endtask

  task automatic put_header(logic [PLEN_W-1:0] plen);
    send_beat(OP_BYTE, 8'($urandom), 1'b1, plen, 8'($urandom));
  endtask

  task automatic take_msg();
    send_beat(OP_MSG, 8'($urandom), 1'($urandom), PLEN_W'($urandom_range(0, 512)),
              8'($urandom));
  endtask

  // Reads a stored byte; an entry never written is swapped for the newest one.
  task automatic read_back(logic [7:0] idx);
    if (!ring_written[idx]) idx = wr_pos - ADDR_W'(1);
    if (ring_written[idx])
      send_beat(OP_READ, 8'($urandom), 1'($urandom), PLEN_W'($urandom_range(0, 512)), idx);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Compares each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    midi_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 16'd1, 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (accepted_o !== want.accepted)
          report_mismatch("accepted", 16'(accepted_o), 16'(want.accepted));
        if (found_o !== want.found)
          report_mismatch("found", 16'(found_o), 16'(want.found));
        if (msg_offset_o !== want.offset)
          report_mismatch("msg_offset", 16'(msg_offset_o), 16'(want.offset));
        if (msg_length_o !== want.length)
          report_mismatch("msg_length", 16'(msg_length_o), 16'(want.length));
        if (read_data_o !== want.rdata)
          report_mismatch("read_data", 16'(read_data_o), 16'(want.rdata));
      end
    end
  end

  // Unknown op and a take on an empty store.
  task automatic test_idle_ops();
    send_beat(OP_NONE, 8'hFF, 1'b1, 10'd512, 8'hFF);
    take_msg();
  endtask

  // Bytes before any header count as an accepted packet; first high byte is a timestamp.
  task automatic test_headerless_bytes();
    put_byte(8'h90);
    put_byte(8'h90);
    put_byte(8'h7F);
    put_byte(8'h00);
    take_msg();
  endtask

  // A packet longer than the free space is ignored whole.
  task automatic test_rejected_packet();
    put_header(10'd512);
    put_byte(8'hFF);
    read_back(8'd0);
  endtask

  task automatic test_lone_end_byte();
    put_header(10'd0);
    put_byte(8'h80);
    put_byte(SYSEX_END);
    take_msg();
  endtask

  // Sysex stays unframed until its end byte is stored, then the end byte stands alone.
  task automatic test_sysex_framing();
    put_byte(8'hFF);
    put_byte(SYSEX_START);
    put_byte(8'h01);
    take_msg();
    put_byte(8'h80);
    put_byte(SYSEX_END);
    take_msg();
    take_msg();
  endtask

  task automatic test_short_message();
    put_byte(8'h80);
    put_byte(8'h90);
    put_byte(8'h3C);
    take_msg();
    put_byte(8'h40);
    take_msg();
  endtask

  // Fills the store to the brim, checks rejection at the edge, then overruns it.
  task automatic test_full_store_overrun();
    logic [ADDR_W-1:0] free_now;
    put_header(10'd0);
    free_now = rd_pos - wr_pos - ADDR_W'(1);
    repeat (int'(free_now) - 2) put_byte(8'($urandom_range(0, 127)));
    put_header(10'd3);
    put_byte(8'h12);
    put_byte(8'h34);
    put_header(10'd2);
    repeat (3) put_byte(8'($urandom_range(0, 127)));
    take_msg();
    read_back(8'd255);
    read_back(8'd0);
    wait_results_drained();
  endtask

  // Builds and sends one well-formed packet with random content, sometimes broken.
  task automatic send_midi_packet(output int n_msgs);
    logic [7:0] body[$];
    int         kind;
    n_msgs = $urandom_range(1, 4);
    repeat (n_msgs) begin
      body.push_back(8'($urandom_range(128, 255)));
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        body.push_back(8'($urandom_range(128, 239)));
        body.push_back(8'($urandom_range(0, 127)));
        body.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 8) begin
        body.push_back(SYSEX_START);
        repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 127)));
        body.push_back(8'($urandom_range(128, 255)));
        body.push_back(SYSEX_END);
      end else begin
        body.push_back(kind == 8 ? SYSEX_END : 8'($urandom_range(241, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) body.delete($urandom_range(0, body.size() - 1));
    put_header(($urandom_range(0, 7) == 0) ? PLEN_W'($urandom_range(0, 512))
                                            : PLEN_W'(body.size() + 1));
    foreach (body[i]) put_byte(body[i]);
  endtask

  task automatic send_noise();
    op_e op;
    op = op_e'(2'($urandom_range(0, 3)));
    if (op == OP_READ)
      read_back(8'($urandom));
    else
      send_beat(op, 8'($urandom), ($urandom_range(0, 7) == 0),
                PLEN_W'($urandom_range(0, 512)), 8'($urandom));
  endtask

  // Mostly well-formed packets followed by takes, with noise, drains and gap changes.
  task automatic test_random_traffic();
    int pick;
    int n_msgs;
    while (n_items < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_midi_packet(n_msgs);
        // Skipping the takes now and then lets the store fill and packets bounce.
        if ($urandom_range(0, 9) != 0) repeat (2 * n_msgs + $urandom_range(0, 1)) take_msg();
        if ($urandom_range(0, 2) == 0) read_back(8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_noise();
      end else if (pick < 94) begin
        wait_results_drained();
      end else begin
        gaps_enabled = ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    op_i              <= OP_NONE;
    data_byte_i       <= '0;
    first_of_packet_i <= 1'b0;
    packet_len_i      <= '0;
    read_index_i      <= '0;
    wr_pos            = '0;
    rd_pos            = '0;
    ts_pending        = 1'b0;
    pkt_rejected      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ops();
    test_headerless_bytes();
    test_rejected_packet();
    test_lone_end_byte();
    test_sysex_framing();
    test_short_message();
    wait_results_drained();
    test_full_store_overrun();
    test_random_traffic();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bmr_pkg.sv
rtl/core/bmr_ram.sv
rtl/core/bmr_ctrl.sv
rtl/core/bmr_datapath.sv
rtl/core/ble_midi_reassembler_unit.sv
sim/ble_midi_reassembler_unit_tb.sv
